@@ rtl/bsru_pkg.sv @@
package bsru_pkg;

  // Storage width of one per-processor mask and of the read data bus.
  localparam int MASK_W        = 8;
  localparam int KIND_W        = 3;
  localparam int TARGET_W      = 3;
  localparam int CHANNEL_W     = 4;
  localparam int PE_W          = 3;
  localparam int DATA_W        = 4;
  localparam int RDATA_W       = 8;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int NUM_PES_DEF      = 8;

  // Access kinds.
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVERT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TEST   = 3'd5;

  // Decoded targets.
  localparam logic [TARGET_W-1:0] TGT_INIT   = 3'd0;
  localparam logic [TARGET_W-1:0] TGT_ENABLE = 3'd1;
  localparam logic [TARGET_W-1:0] TGT_CHECK  = 3'd2;
  localparam logic [TARGET_W-1:0] TGT_SYNC   = 3'd3;

  // One access as held in the input register.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TARGET_W-1:0]  target;
    logic [CHANNEL_W-1:0] channel;
    logic [PE_W-1:0]      pe_index;
    logic [DATA_W-1:0]    write_data;
    logic [DATA_W-1:0]    bit_mask;
  } access_t;

  // The three masks of one barrier channel.
  typedef struct packed {
    logic [MASK_W-1:0] enable;
    logic [MASK_W-1:0] check;
    logic [MASK_W-1:0] sync;
  } masks_t;

  // One result item.
  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic               read_valid;
    logic               zero_valid;
    logic               zero_flag;
  } result_t;

endpackage

@@ rtl/bsru_access.sv @@
module bsru_access import bsru_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_PES      = NUM_PES_DEF
) (
  input  access_t acc,
  input  masks_t  cur,
  output logic    wr_en,
  output masks_t  nxt,
  output result_t res
);

  // Bits of processors that exist.
  localparam logic [MASK_W-1:0] PE_VALID = MASK_W'((16'(1) << NUM_PES) - 16'(1));

  // Set/clear sel bits; invert: clear if any set, else set; test: keep.
  function automatic logic [MASK_W-1:0] apply_bitop(input logic [MASK_W-1:0] value,
                                                    input logic [MASK_W-1:0] sel,
                                                    input logic [KIND_W-1:0] kind);
    logic [MASK_W-1:0] r;
    r = value;
    if (kind == KIND_SET) begin
      r = value | sel;
    end else if (kind == KIND_INVERT) begin
      r = (|(value & sel)) ? (value & ~sel) : (value | sel);
    end else if (kind == KIND_CLEAR) begin
      r = value & ~sel;
    end
    return r;
  endfunction

  logic              bitop;
  logic              chan_ok;
  logic              mapped;
  logic              eval;
  logic [MASK_W-1:0] pe_bit;
  logic [MASK_W-1:0] en_sel;
  logic [MASK_W-1:0] pe_sel;

  assign bitop   = (acc.kind == KIND_SET) || (acc.kind == KIND_INVERT) ||
                   (acc.kind == KIND_CLEAR) || (acc.kind == KIND_TEST);
  assign chan_ok = ({1'b0, acc.channel} < (CHANNEL_W + 1)'(NUM_CHANNELS));
  assign mapped  = ((acc.kind == KIND_READ) || (acc.kind == KIND_WRITE) || bitop) &&
                   chan_ok && (acc.target <= TGT_SYNC);
  assign pe_bit  = (MASK_W'(1) << acc.pe_index) & PE_VALID;
  assign en_sel  = MASK_W'(acc.bit_mask) & PE_VALID;
  assign pe_sel  = acc.bit_mask[0] ? pe_bit : '0;
  assign wr_en   = mapped;

  // Read-modify-write of the addressed channel.
  always_comb begin
    nxt            = cur;
    eval           = 1'b0;
    res.read_data  = '0;
    res.read_valid = (acc.kind == KIND_READ);
    res.zero_valid = 1'b0;
    res.zero_flag  = 1'b0;
    if (mapped) begin
      unique case (acc.target)
        TGT_INIT: begin
          // Init bit ops flag zero; init clears the barrier on request.
          if (bitop) begin
            res.zero_valid = 1'b1;
            res.zero_flag  = 1'b1;
            if ((acc.kind == KIND_SET) && (acc.bit_mask == DATA_W'(1))) begin
              nxt.check = '0;
              nxt.sync  = '0;
            end
          end else if (acc.kind == KIND_WRITE) begin
            if (acc.write_data[0]) begin
              nxt.check = '0;
              nxt.sync  = '0;
            end
          end
        end
        TGT_ENABLE: begin
          eval = 1'b1;
          if (bitop) begin
            res.zero_valid = 1'b1;
            res.zero_flag  = ~|(cur.enable & en_sel);
            nxt.enable     = apply_bitop(cur.enable, en_sel, acc.kind);
          end else if (acc.kind == KIND_WRITE) begin
            nxt.enable = MASK_W'(acc.write_data) & PE_VALID;
          end else begin
            res.read_data = RDATA_W'(cur.enable);
          end
        end
        TGT_CHECK: begin
          // Every modifying access to a check bit only sets it.
          eval = 1'b1;
          if (bitop) begin
            res.zero_valid = 1'b1;
            res.zero_flag  = ~|(cur.check & pe_sel);
            if (acc.kind != KIND_TEST) begin
              nxt.check = cur.check | pe_sel;
            end
          end else if (acc.kind == KIND_WRITE) begin
            nxt.check = cur.check | pe_bit;
          end else begin
            res.read_data = RDATA_W'(|(cur.check & pe_bit));
          end
        end
        TGT_SYNC: begin
          if (bitop) begin
            res.zero_valid = 1'b1;
            res.zero_flag  = ~|(cur.sync & pe_sel);
            nxt.sync       = apply_bitop(cur.sync, pe_sel, acc.kind);
          end else if (acc.kind == KIND_WRITE) begin
            if (acc.write_data[0]) begin
              nxt.sync = cur.sync | pe_bit;
            end
          end else begin
            res.read_data = RDATA_W'(|(cur.sync & pe_bit));
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
      // Release the barrier once every enabled processor has checked in.
      if (eval && ((nxt.enable & nxt.check) == nxt.enable)) begin
        nxt.sync = nxt.enable;
      end
    end
  end

endmodule

@@ rtl/barrier_sync_register_unit.sv @@
// Barrier synchronization register unit: each barrier channel holds an enable
// mask, a check mask and a sync mask, one bit per processor, in flip-flops
// that reset clears. Every transfer on the input channel is one decoded access
// (read, write, or a set/invert/clear/test bit operation) and yields exactly
// one result transfer. The unit takes one access per clock cycle unless
// in_stall is high; the result is registered as the access passes from the
// input register into the result register, and in that same cycle the
// addressed channel's masks are read, modified and written back, so a
// following access to the same channel always sees the update. in_stall
// rises only while a result is held by out_stall and the input register is
// full.
module barrier_sync_register_unit import bsru_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_PES      = NUM_PES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [TARGET_W-1:0]  in_target,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [PE_W-1:0]      in_pe_index,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic [DATA_W-1:0]    in_bit_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RDATA_W-1:0]   out_read_data,
  output logic                 out_read_valid,
  output logic                 out_zero_valid,
  output logic                 out_zero_flag
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic              acc_valid_r;
  access_t           acc_r;
  logic              out_valid_r;
  result_t           res_r;
  logic [MASK_W-1:0] enable_mask_r [NUM_CHANNELS];
  logic [MASK_W-1:0] check_mask_r  [NUM_CHANNELS];
  logic [MASK_W-1:0] sync_mask_r   [NUM_CHANNELS];

  logic                advance;
  logic                fire;
  logic [CH_IDX_W-1:0] ch_idx;
  masks_t              cur;
  masks_t              nxt;
  logic                wr_en;
  result_t             res_nxt;

  // The input register moves on whenever the result register is free.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = acc_valid_r && advance;
  assign in_stall = acc_valid_r && !advance;

  assign ch_idx     = acc_r.channel[CH_IDX_W-1:0];
  assign cur.enable = enable_mask_r[ch_idx];
  assign cur.check  = check_mask_r[ch_idx];
  assign cur.sync   = sync_mask_r[ch_idx];

  bsru_access #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PES      (NUM_PES)
  ) u_access (
    .acc   (acc_r),
    .cur   (cur),
    .wr_en (wr_en),
    .nxt   (nxt),
    .res   (res_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else if (!in_stall) begin
      acc_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      acc_r.kind       <= in_kind;
      acc_r.target     <= in_target;
      acc_r.channel    <= in_channel;
      acc_r.pe_index   <= in_pe_index;
      acc_r.write_data <= in_write_data;
      acc_r.bit_mask   <= in_bit_mask;
    end
  end

  // Channel masks, written back as the access moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        enable_mask_r[i] <= '0;
        check_mask_r[i]  <= '0;
        sync_mask_r[i]   <= '0;
      end
    end else if (fire && wr_en) begin
      enable_mask_r[ch_idx] <= nxt.enable;
      check_mask_r[ch_idx]  <= nxt.check;
      sync_mask_r[ch_idx]   <= nxt.sync;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= acc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = res_r.read_data;
  assign out_read_valid = res_r.read_valid;
  assign out_zero_valid = res_r.zero_valid;
  assign out_zero_flag  = res_r.zero_flag;

endmodule

@@ rtl/bsru_checker.sv @@
module bsru_checker import bsru_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [RDATA_W-1:0] out_read_data,
  input logic               out_read_valid,
  input logic               out_zero_valid,
  input logic               out_zero_flag
);

  // A plain read never reports a zero flag.
  a_read_xor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_valid && out_zero_valid))
    else $error("read and zero flag reported by the same transfer");

  // Read data is zero unless the access was a read.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_read_valid) |-> (out_read_data == '0))
    else $error("nonzero read data on a non-read transfer");

  // The zero flag is low when it was not updated.
  a_zflag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_valid) |-> !out_zero_flag)
    else $error("zero flag set without zero valid");

  // The input side stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result side is free");

endmodule

bind barrier_sync_register_unit bsru_checker u_bsru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_read_valid (out_read_valid),
  .out_zero_valid (out_zero_valid),
  .out_zero_flag  (out_zero_flag)
);
